FILE: design/dppc_pkg.sv
package dppc_pkg;

    // Width of the configuration register index
    localparam int CFG_INDEX_BITS = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START_R,
        ST_WAIT_R,
        ST_WAIT_F,
        ST_FINISH
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;    // capture input beat
        logic div_start;  // launch divider on selected sensor
        logic sel_fall;   // 0 rising sensor, 1 falling sensor
        logic cap_rise;   // store rising fraction
        logic cap_fall;   // store falling fraction
        logic commit;     // update output register and latch state
    } dppc_cmd_t;

endpackage

FILE: design/dppc_divider.sv
module dppc_divider #(
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 12
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [SAMPLE_BITS-1:0]   num,
    input  logic [SAMPLE_BITS-1:0]   den,
    input  logic                     force_zero,
    input  logic                     saturate,
    output logic                     done,
    output logic [FRACTION_BITS:0]   quotient
);

    localparam int CW = $clog2(FRACTION_BITS);
    localparam int LW = FRACTION_BITS + 1;

    logic [SAMPLE_BITS:0]     rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0]   den_reg, den_next;
    logic [FRACTION_BITS-1:0] quot_reg, quot_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic                     zero_reg, zero_next;
    logic                     sat_reg, sat_next;

    logic [SAMPLE_BITS:0]     shifted;
    logic                     ge;
    logic                     last;

    // Restoring division, one quotient bit per cycle. Remainder starts below den unless zeroed or saturated.
    always_comb begin
        shifted   = {rem_reg[SAMPLE_BITS-1:0], 1'b0};
        ge        = shifted >= {1'b0, den_reg};
        last      = cnt_reg == CW'(FRACTION_BITS - 1);
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        zero_next = zero_reg;
        sat_next  = sat_reg;
        if (start) begin
            rem_next  = {1'b0, num};
            den_next  = den;
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            zero_next = force_zero;
            sat_next  = saturate;
        end else if (busy_reg) begin
            rem_next  = ge ? shifted - {1'b0, den_reg} : shifted;
            quot_next = {quot_reg[FRACTION_BITS-2:0], ge};
            cnt_next  = cnt_reg + CW'(1);
            if (last) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
        zero_reg <= zero_next;
        sat_reg  <= sat_next;
    end

    assign done = done_reg;

    always_comb begin
        if (zero_reg) begin
            quotient = '0;
        end else if (sat_reg) begin
            quotient = LW'(1) << FRACTION_BITS;
        end else begin
            quotient = {1'b0, quot_reg};
        end
    end

endmodule

FILE: design/dppc_controller.sv
module dppc_controller (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  logic               div_done,
    output dppc_pkg::dppc_cmd_t cmd
);

    import dppc_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_tvalid) state_next = ST_START_R;
            ST_START_R: state_next = ST_WAIT_R;
            ST_WAIT_R:  if (div_done) state_next = ST_WAIT_F;
            ST_WAIT_F:  if (div_done) state_next = ST_FINISH;
            ST_FINISH:  if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_START_R: begin
                cmd.div_start = 1'b1;
            end
            ST_WAIT_R: begin
                cmd.cap_rise  = div_done;
                cmd.div_start = div_done;
                cmd.sel_fall  = 1'b1;
            end
            ST_WAIT_F: begin
                cmd.cap_fall = div_done;
                cmd.sel_fall = 1'b1;
            end
            ST_FINISH: begin
                cmd.commit = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    // commit never overwrites a result that is still waiting
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!out_valid_reg || m_tready))
        else $error("commit while output beat pending");

    // one item at a time: no second input beat right after an accepted one
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");

    // divider completes only while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_WAIT_R || state_reg == ST_WAIT_F))
        else $error("divider done outside wait state");

endmodule

FILE: design/dppc_datapath.sv
module dppc_datapath #(
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 12,
    parameter int CFG_DATA_BITS = 13
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dppc_pkg::dppc_cmd_t                 cmd,
    input  logic [SAMPLE_BITS-1:0]              in_rising,
    input  logic [SAMPLE_BITS-1:0]              in_falling,
    input  logic [FRACTION_BITS:0]              in_brake,
    input  logic                                cfg_we,
    input  logic [dppc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]            cfg_data,
    output logic                                div_done,
    output logic [FRACTION_BITS:0]              pedal_level,
    output logic                                fault_latched,
    output logic [1:0]                          fault_cause
);

    import dppc_pkg::*;

    localparam int S        = SAMPLE_BITS;
    localparam int LW       = FRACTION_BITS + 1;
    localparam int SMASK    = (1 << SAMPLE_BITS) - 1;
    localparam int FRAC_ONE = 1 << FRACTION_BITS;

    localparam logic [S-1:0]  LOW_RST  = S'(SMASK / 10);
    localparam logic [S-1:0]  HIGH_RST = S'((SMASK * 9) / 10);
    localparam logic [S-1:0]  GAP_RST  = S'(100 & SMASK);
    localparam logic [LW-1:0] MIS_RST  = LW'((FRAC_ONE + 9) / 10);
    localparam logic [LW-1:0] ONE      = LW'(FRAC_ONE);
    localparam logic [LW-1:0] BRAKE_T  = LW'(FRAC_ONE / 5);
    localparam logic [LW-1:0] PREV_T   = LW'(FRAC_ONE / 10);
    localparam logic [LW-1:0] DEADBAND = LW'((FRAC_ONE + 19) / 20);

    localparam logic [CFG_INDEX_BITS-1:0] REG_LOW      = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH     = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_R_START  = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_R_STOP   = CFG_INDEX_BITS'(3);
    localparam logic [CFG_INDEX_BITS-1:0] REG_F_START  = CFG_INDEX_BITS'(4);
    localparam logic [CFG_INDEX_BITS-1:0] REG_F_STOP   = CFG_INDEX_BITS'(5);
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAP      = CFG_INDEX_BITS'(6);
    localparam logic [CFG_INDEX_BITS-1:0] REG_MISMATCH = CFG_INDEX_BITS'(7);

    localparam logic [1:0] CAUSE_NONE     = 2'd0;
    localparam logic [1:0] CAUSE_RANGE    = 2'd1;
    localparam logic [1:0] CAUSE_MISMATCH = 2'd2;
    localparam logic [1:0] CAUSE_LATCHED  = 2'd3;

    // configuration
    logic [S-1:0]  low_reg, high_reg, r_start_reg, r_stop_reg;
    logic [S-1:0]  f_start_reg, f_stop_reg, gap_reg;
    logic [LW-1:0] mismatch_reg;

    // item registers
    logic [S-1:0]  rise_reg, fall_reg;
    logic [LW-1:0] brake_reg;
    logic [LW-1:0] frac_r_reg, frac_f_reg;

    // block state and output beat
    logic          latch_reg, latch_next;
    logic [LW-1:0] prev_reg;
    logic [LW-1:0] level_reg, level_next;
    logic [1:0]    cause_reg, cause_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg      <= LOW_RST;
            high_reg     <= HIGH_RST;
            r_start_reg  <= LOW_RST;
            r_stop_reg   <= HIGH_RST;
            f_start_reg  <= HIGH_RST;
            f_stop_reg   <= LOW_RST;
            gap_reg      <= GAP_RST;
            mismatch_reg <= MIS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LOW:      low_reg      <= cfg_data[S-1:0];
                REG_HIGH:     high_reg     <= cfg_data[S-1:0];
                REG_R_START:  r_start_reg  <= cfg_data[S-1:0];
                REG_R_STOP:   r_stop_reg   <= cfg_data[S-1:0];
                REG_F_START:  f_start_reg  <= cfg_data[S-1:0];
                REG_F_STOP:   f_stop_reg   <= cfg_data[S-1:0];
                REG_GAP:      gap_reg      <= cfg_data[S-1:0];
                REG_MISMATCH: mismatch_reg <= cfg_data[LW-1:0];
                default:      ;
            endcase
        end
    end

    // divider operand selection
    logic [S-1:0]  op_sample, op_start, op_stop;
    logic [S-1:0]  num_diff, den_diff;
    logic          op_zero, op_sat;
    logic [LW-1:0] quotient;

    always_comb begin
        op_sample = cmd.sel_fall ? fall_reg    : rise_reg;
        op_start  = cmd.sel_fall ? f_start_reg : r_start_reg;
        op_stop   = cmd.sel_fall ? f_stop_reg  : r_stop_reg;
        num_diff  = (op_sample > op_start) ? op_sample - op_start : op_start - op_sample;
        den_diff  = (op_stop > op_start) ? op_stop - op_start : op_start - op_stop;
        // wrong direction, on the start point, or a flat span: zero travel
        op_zero   = (op_start == op_stop) || (op_sample == op_start) ||
                    ((op_sample < op_start) != (op_stop < op_start));
        // at or past the end point: clamp to full travel
        op_sat    = num_diff >= den_diff;
    end

    dppc_divider #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .num       (num_diff),
        .den       (den_diff),
        .force_zero(op_zero),
        .saturate  (op_sat),
        .done      (div_done),
        .quotient  (quotient)
    );

    // final decision
    logic [S-1:0]  raw_gap;
    logic          range_fault, mismatch_fault;
    logic [LW-1:0] frac_gap;
    logic [LW:0]   frac_sum;
    logic [LW-1:0] mean;
    logic          latch_set, latch_hold;

    always_comb begin
        raw_gap  = (rise_reg > fall_reg) ? rise_reg - fall_reg : fall_reg - rise_reg;
        range_fault = (rise_reg < low_reg) || (rise_reg > high_reg) ||
                      (fall_reg < low_reg) || (fall_reg > high_reg) ||
                      (raw_gap < gap_reg);
        frac_gap = (frac_r_reg > frac_f_reg) ? frac_r_reg - frac_f_reg
                                             : frac_f_reg - frac_r_reg;
        mismatch_fault = frac_gap > mismatch_reg;
        frac_sum = {1'b0, frac_r_reg} + {1'b0, frac_f_reg};
        mean     = frac_sum[LW:1];
        latch_set  = latch_reg || ((brake_reg > BRAKE_T) && (prev_reg > PREV_T));
        latch_hold = (mean < DEADBAND) ? 1'b0 : latch_set;

        if (range_fault) begin
            latch_next = 1'b1;
            level_next = '0;
            cause_next = CAUSE_RANGE;
        end else if (mismatch_fault) begin
            latch_next = 1'b1;
            level_next = '0;
            cause_next = CAUSE_MISMATCH;
        end else if (latch_hold) begin
            latch_next = 1'b1;
            level_next = '0;
            cause_next = CAUSE_LATCHED;
        end else begin
            latch_next = 1'b0;
            cause_next = CAUSE_NONE;
            if (mean > ONE) begin
                level_next = ONE;
            end else if (mean < DEADBAND) begin
                level_next = '0;
            end else begin
                level_next = mean;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_reg <= 1'b0;
            prev_reg  <= '0;
        end else if (cmd.commit) begin
            latch_reg <= latch_next;
            prev_reg  <= level_next;
        end
        if (cmd.load_in) begin
            rise_reg  <= in_rising;
            fall_reg  <= in_falling;
            brake_reg <= in_brake;
        end
        if (cmd.cap_rise) frac_r_reg <= quotient;
        if (cmd.cap_fall) frac_f_reg <= quotient;
        if (cmd.commit) begin
            level_reg <= level_next;
            cause_reg <= cause_next;
        end
    end

    assign pedal_level   = level_reg;
    assign fault_latched = latch_reg;
    assign fault_cause   = cause_reg;

endmodule

FILE: design/dual_pedal_plausibility_check.sv
// Dual accelerator pedal sensor plausibility check.
//
// Input channel s_*: one beat carries a rising sensor sample, a falling
// sensor sample and the brake travel. Output channel m_*: one beat per input
// beat with the accepted pedal travel, the latch flag and the fault cause.
// Configuration channel cfg_*: writes register cfg_index with cfg_data; it is
// always ready and is meant to be written while no item is in flight.
//
// The shared restoring divider, one quotient bit per cycle, is run once per
// sensor, rising first, then falling; the result is then committed to the
// output register. One item is worked on at a time, so a new input beat is
// taken only after the current item has been committed.
// A finished beat sits in the output register; the next item is accepted and
// computed meanwhile and waits only for that register to drain.
//
// Reset (synchronous, aresetn low) loads the default limits and calibration,
// clears the implausibility latch and the previous travel, and drops m_tvalid.
// A stalled receiver holds m_tdata stable until m_tready.
module dual_pedal_plausibility_check #(
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 12,
    localparam int IN_BITS      = 2 * SAMPLE_BITS + FRACTION_BITS + 1,
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS     = FRACTION_BITS + 4,
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8,
    localparam int CFG_DATA_W   = (SAMPLE_BITS > FRACTION_BITS + 1) ? SAMPLE_BITS
                                                                    : FRACTION_BITS + 1
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // rising_sample, falling_sample, brake_level, zero pad
    input  logic [IN_TDATA_W-1:0]               s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pedal_level, fault_latched, fault_cause, zero pad
    output logic [OUT_TDATA_W-1:0]              m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dppc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]               cfg_data
);

    import dppc_pkg::*;

    localparam int S  = SAMPLE_BITS;
    localparam int LW = FRACTION_BITS + 1;

    dppc_cmd_t     cmd;
    logic          div_done;
    logic [LW-1:0] pedal_level;
    logic          fault_latched;
    logic [1:0]    fault_cause;

    // registers take writes every cycle
    assign cfg_ready = 1'b1;

    dppc_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .div_done(div_done),
        .cmd     (cmd)
    );

    dppc_datapath #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .FRACTION_BITS(FRACTION_BITS),
        .CFG_DATA_BITS(CFG_DATA_W)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .in_rising    (s_tdata[S-1:0]),
        .in_falling   (s_tdata[2*S-1:S]),
        .in_brake     (s_tdata[2*S+LW-1:2*S]),
        .cfg_we       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .div_done     (div_done),
        .pedal_level  (pedal_level),
        .fault_latched(fault_latched),
        .fault_cause  (fault_cause)
    );

    assign m_tdata = OUT_TDATA_W'({fault_cause, fault_latched, pedal_level});

endmodule
